[sv/rpc_pkg.sv]
// Shared constants, types and symbol lookup for the password character generator.
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int unsigned MIN_LENGTH_DEF = 8;
  localparam int unsigned MAX_LENGTH_DEF = 64;
  localparam int unsigned RESULT_CAP     = 64;

  localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] XS_MULT     = 64'h2545_F491_4F6C_DD1D;

  // Only product bits 40..33 are used, so only the low 41 bits of each operand matter.
  localparam int unsigned PROD_W  = 41;
  localparam int unsigned HALF_W  = 21;
  localparam int unsigned NUM_TERMS = 3;

  localparam int unsigned ALPHA_SIZE   = 67;
  localparam int unsigned ACCEPT_LIMIT = 256 - (256 % ALPHA_SIZE);

  localparam logic [ALPHA_SIZE*8-1:0] ALPHABET =
    {"ABCDEFGHJKLMNPQRSTUVWXYZ", "abcdefghijkmnpqrstuvwxyz", "23456789", "!@#%^&*-_=+"};

  typedef struct packed {
    logic       done;
    logic [7:0] rnd_byte;
  } mul_res_t;

  // Byte below ACCEPT_LIMIT -> ASCII symbol at (byte mod 67).
  function automatic logic [6:0] byte_to_symbol(input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] ch;
    if (b >= 8'(2 * ALPHA_SIZE)) begin
      r = b - 8'(2 * ALPHA_SIZE);
    end else if (b >= 8'(ALPHA_SIZE)) begin
      r = b - 8'(ALPHA_SIZE);
    end else begin
      r = b;
    end
    ch = ALPHABET[8 * (ALPHA_SIZE - 1 - int'(r[6:0])) +: 8];
    return ch[6:0];
  endfunction

endpackage

[sv/random_password_char_generator.sv]
// Top level: request sequencer, xorshift64* state, rejection and output register.
//
// Input channel: requested_length_i with in_valid_i / in_stall_o. The wanted
// length is clamped to MIN_LENGTH..MAX_LENGTH and at most 64, and that many
// beats follow on the output channel (symbol_o, last_o with out_valid_o /
// out_stall_i); last_o marks the final beat of a request.
// in_stall_o is high from acceptance until the final beat is loaded into the
// output register, so one request is worked on at a time.
// Each draw makes one xorshift step, then the shared 21x21
// multiplier forms three partial products of the low 41 product bits, then the
// byte is checked. Bytes of 201 or more are dropped, about 1.27 draws per
// character. A stalled receiver holds the output register; the sequencer
// waits with the next accepted character until the register is free.
// Reset loads the generator with the golden constant. A write on cfg_we_i
// sets the seed and reloads the generator at once (zero maps to the golden
// constant); write only while idle. The generator state carries across requests.
`timescale 1ns / 1ps

module random_password_char_generator #(
  parameter int unsigned MIN_LENGTH = rpc_pkg::MIN_LENGTH_DEF,
  parameter int unsigned MAX_LENGTH = rpc_pkg::MAX_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  requested_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  symbol_o,
  output logic        last_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [7:0] MIN_L = 8'(MIN_LENGTH);
  localparam logic [7:0] MAX_L = 8'(MAX_LENGTH);
  localparam logic [7:0] CAP_L = 8'(rpc_pkg::RESULT_CAP);

  logic [1:0]  state_q, state_d;
  logic [63:0] gen_q, gen_d;
  logic [6:0]  left_q, left_d;
  logic        out_valid_q, out_valid_d;
  logic [6:0]  symbol_q, symbol_d;
  logic        last_q, last_d;

  logic [63:0] xs1, xs2, xs3;
  logic [7:0]  len_a, len_b, len_c;
  logic        mul_start;
  logic        byte_ok;
  logic        out_free;
  rpc_pkg::mul_res_t mul_res;

  always_comb begin
    xs1 = gen_q ^ (gen_q >> 12);
    xs2 = xs1 ^ (xs1 << 25);
    xs3 = xs2 ^ (xs2 >> 27);
  end

  always_comb begin
    len_a = (requested_length_i < MIN_L) ? MIN_L : requested_length_i;
    len_b = (len_a > MAX_L) ? MAX_L : len_a;
    len_c = (len_b > CAP_L) ? CAP_L : len_b;
  end

  assign byte_ok   = mul_res.rnd_byte < 8'(rpc_pkg::ACCEPT_LIMIT);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign mul_start = (state_q == S_STEP);

  rpc_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (xs3[rpc_pkg::PROD_W-1:0]),
    .res_o     (mul_res)
  );

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && out_stall_i;
    symbol_d    = symbol_q;
    last_d      = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          gen_d = (cfg_wdata_i == '0) ? rpc_pkg::GOLDEN_SEED : cfg_wdata_i;
        end
        if (in_valid_i) begin
          left_d  = len_c[6:0];
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        gen_d   = xs3;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (mul_res.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!byte_ok) begin
          state_d = S_STEP;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          symbol_d    = rpc_pkg::byte_to_symbol(mul_res.rnd_byte);
          last_d      = (left_q == 7'd1);
          left_d      = left_q - 7'd1;
          state_d     = (left_q == 7'd1) ? S_IDLE : S_STEP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_q       <= rpc_pkg::GOLDEN_SEED;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

  a_left_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (left_q != 7'd0))
    else $error("busy with no characters left");

  a_done_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_res.done |-> (state_q == S_MUL))
    else $error("multiplier result outside wait state");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && byte_ok && out_free && left_q == 7'd1)
      |=> (state_q == S_IDLE && out_valid_q && last_q))
    else $error("final beat did not end the request");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(symbol_q) && $stable(last_q)))
    else $error("held beat overwritten");

endmodule

[sv/rpc_mul.sv]
// Iterative low-half multiplier: one shared 21x21 multiplier, three partial products.
`timescale 1ns / 1ps

module rpc_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rpc_pkg::PROD_W-1:0]  operand_i,
  output rpc_pkg::mul_res_t           res_o
);

  localparam int unsigned PW = rpc_pkg::PROD_W;
  localparam int unsigned HW = rpc_pkg::HALF_W;
  localparam logic [PW-1:0] MC = rpc_pkg::XS_MULT[PW-1:0];

  logic [PW-1:0]   a_q, a_d;
  logic [PW-1:0]   acc_q, acc_d;
  logic [1:0]      step_q, step_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [HW-1:0]   op_a, op_b;
  logic [2*HW-1:0] prod;
  logic [PW-1:0]   term;

  // a*m mod 2^41 = a0*m0 + ((a0*m1 + a1*m0) << 21)
  always_comb begin
    op_a = (step_q == 2'd2) ? {1'b0, a_q[PW-1:HW]} : a_q[HW-1:0];
    op_b = (step_q == 2'd1) ? {1'b0, MC[PW-1:HW]} : MC[HW-1:0];
    prod = op_a * op_b;
    if (step_q == 2'd0) begin
      term = prod[PW-1:0];
    end else begin
      term = {prod[PW-HW-1:0], {HW{1'b0}}};
    end
  end

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = operand_i;
      acc_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = acc_q + term;
      step_d = step_q + 2'd1;
      if (step_q == 2'(rpc_pkg::NUM_TERMS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign res_o.done     = done_q;
  assign res_o.rnd_byte = acc_q[40:33];

endmodule
